// ===== design/itra_pkg.sv =====
// Shared types, constants and helpers for the integer to radix ASCII converter.
package itra_pkg;

   typedef logic [3:0] digit_type;
   typedef logic [7:0] char_type;

   typedef enum logic [1:0] {
      BASE_DEC = 2'd0,
      BASE_HEX = 2'd1,
      BASE_OCT = 2'd2,
      BASE_BIN = 2'd3
   } base_type;

   localparam char_type  CHAR_ZERO    = 8'h30;
   localparam char_type  CHAR_MINUS   = 8'h2D;
   localparam char_type  ALPHA_OFFSET = 8'd55;
   localparam digit_type DIGIT_TEN    = 4'd10;
   localparam digit_type DABBLE_LIMIT = 4'd5;
   localparam digit_type DABBLE_ADD   = 4'd3;

   typedef struct packed {
      logic     load;
      logic     step;
      base_type base;
   } conv_ctrl_type;

   function automatic char_type digit_char(digit_type d);
      char_type wide;
      wide = {4'b0000, d};
      if (d >= DIGIT_TEN) begin
         return wide + ALPHA_OFFSET;
      end
      return wide + CHAR_ZERO;
   endfunction

endpackage

// ===== design/itra_conv.sv =====
// Digit store: loads power-of-two digits directly, builds BCD by shift-add-3.
module itra_conv #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                   clock,
   input  itra_pkg::conv_ctrl_type                ctrl,
   input  logic [VALUE_WIDTH-1:0]                 mag,
   input  logic [$clog2(VALUE_WIDTH)-1:0]         rd_idx,
   output itra_pkg::digit_type                    rd_digit
);
   import itra_pkg::*;

   localparam int NUM_DIGITS = VALUE_WIDTH;
   localparam int NUM_DEC    = (VALUE_WIDTH * 30103) / 100000 + 1;

   digit_type                  dig_ff [NUM_DIGITS];
   digit_type                  dig_in [NUM_DIGITS];
   logic [VALUE_WIDTH-1:0]     shift_ff;
   logic [VALUE_WIDTH-1:0]     shift_in;
   logic [4*NUM_DIGITS-1:0]    mag_pad;
   digit_type                  adj [NUM_DEC];

   assign mag_pad  = {{(4*NUM_DIGITS-VALUE_WIDTH){1'b0}}, mag};
   assign rd_digit = dig_ff[rd_idx];

   always_comb begin
      for (int i = 0; i < NUM_DEC; i++) begin
         adj[i] = (dig_ff[i] >= DABBLE_LIMIT) ? dig_ff[i] + DABBLE_ADD : dig_ff[i];
      end
      dig_in   = dig_ff;
      shift_in = shift_ff;
      if (ctrl.load) begin
         shift_in = mag;
         for (int p = 0; p < NUM_DIGITS; p++) begin
            unique case (ctrl.base)
               BASE_DEC: dig_in[p] = '0;
               BASE_HEX: dig_in[p] = mag_pad[4*p +: 4];
               BASE_OCT: dig_in[p] = {1'b0, mag_pad[3*p +: 3]};
               BASE_BIN: dig_in[p] = {3'b000, mag_pad[p]};
               default:  dig_in[p] = '0;
            endcase
         end
      end else if (ctrl.step) begin
         shift_in = {shift_ff[VALUE_WIDTH-2:0], 1'b0};
         dig_in[0] = {adj[0][2:0], shift_ff[VALUE_WIDTH-1]};
         for (int i = 1; i < NUM_DEC; i++) begin
            dig_in[i] = {adj[i][2:0], adj[i-1][3]};
         end
      end
   end

   always_ff @(posedge clock) begin
      dig_ff   <= dig_in;
      shift_ff <= shift_in;
   end

endmodule

// ===== design/integer_to_radix_ascii_top.sv =====
// Signed integer to ASCII text in base 10, 16, 8 or 2, one character per strobe.
// Busy: a sign step if negative, then one step per digit position scanned (VALUE_WIDTH bin,
// (VALUE_WIDTH+2)/3 oct, (VALUE_WIDTH+3)/4 hex, 10 dec at 32 bits); decimal first runs one
// shift-add-3 step per magnitude bit. Leading zeros are scanned but not shown. A new item is
// taken only once the block has returned to idle.
// Reset: synchronous, clears the sequencer and the strobe; results cannot be stalled.
module integer_to_radix_ascii_top #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   input  logic [1:0]                    req_base_select,
   output logic                          rsp_strobe,
   output itra_pkg::char_type            rsp_char_code,
   output logic                          rsp_last_char
);
   import itra_pkg::*;

   localparam int CNT_WIDTH = $clog2(VALUE_WIDTH + 1);
   localparam int IDX_WIDTH = $clog2(VALUE_WIDTH);
   localparam int NUM_DEC   = (VALUE_WIDTH * 30103) / 100000 + 1;
   localparam logic [CNT_WIDTH-1:0] CNT_BIN = CNT_WIDTH'(VALUE_WIDTH);
   localparam logic [CNT_WIDTH-1:0] CNT_OCT = CNT_WIDTH'((VALUE_WIDTH + 2) / 3);
   localparam logic [CNT_WIDTH-1:0] CNT_HEX = CNT_WIDTH'((VALUE_WIDTH + 3) / 4);
   localparam logic [CNT_WIDTH-1:0] CNT_DEC = CNT_WIDTH'(NUM_DEC);
   localparam logic [CNT_WIDTH-1:0] CNT_ONE = CNT_WIDTH'(1);
   localparam logic [VALUE_WIDTH-1:0] VAL_ONE = VALUE_WIDTH'(1);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DABBLE = 4'b0010,
      ST_SIGN   = 4'b0100,
      ST_EMIT   = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   logic [CNT_WIDTH-1:0]   cnt_ff, cnt_in, cnt_m1, cnt_load;
   logic                   neg_ff, neg_in;
   logic                   started_ff, started_in;
   logic                   strobe_ff, strobe_in;
   char_type               char_ff, char_in;
   logic                   last_ff, last_in;
   logic                   accept, is_last;
   logic [VALUE_WIDTH-1:0] val_u, mag;
   base_type               base;
   conv_ctrl_type          ctrl;
   digit_type              rd_digit;
   logic [IDX_WIDTH-1:0]   rd_idx;

   assign accept = start & ~busy;
   assign busy   = (state_ff != ST_IDLE);
   assign val_u  = req_value;
   assign mag    = val_u[VALUE_WIDTH-1] ? (~val_u + VAL_ONE) : val_u;
   assign base   = base_type'(req_base_select);
   assign cnt_m1 = cnt_ff - CNT_ONE;
   assign rd_idx = cnt_m1[IDX_WIDTH-1:0];
   assign is_last = (cnt_ff == CNT_ONE);

   always_comb begin
      unique case (base)
         BASE_DEC: cnt_load = CNT_DEC;
         BASE_HEX: cnt_load = CNT_HEX;
         BASE_OCT: cnt_load = CNT_OCT;
         BASE_BIN: cnt_load = CNT_BIN;
         default:  cnt_load = CNT_BIN;
      endcase
   end

   itra_conv #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_conv (
      .clock    (clock),
      .ctrl     (ctrl),
      .mag      (mag),
      .rd_idx   (rd_idx),
      .rd_digit (rd_digit)
   );

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      neg_in     = neg_ff;
      started_in = started_ff;
      strobe_in  = 1'b0;
      char_in    = char_ff;
      last_in    = 1'b0;
      ctrl.load  = accept;
      ctrl.step  = 1'b0;
      ctrl.base  = base;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               neg_in     = val_u[VALUE_WIDTH-1];
               started_in = 1'b0;
               if (base == BASE_DEC) begin
                  state_in = ST_DABBLE;
                  cnt_in   = CNT_BIN;
               end else begin
                  state_in = val_u[VALUE_WIDTH-1] ? ST_SIGN : ST_EMIT;
                  cnt_in   = cnt_load;
               end
            end
         end
         ST_DABBLE: begin
            ctrl.step = 1'b1;
            cnt_in    = cnt_m1;
            if (is_last) begin
               cnt_in   = CNT_DEC;
               state_in = neg_ff ? ST_SIGN : ST_EMIT;
            end
         end
         ST_SIGN: begin
            strobe_in = 1'b1;
            char_in   = CHAR_MINUS;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (is_last || started_ff || (rd_digit != '0)) begin
               strobe_in  = 1'b1;
               char_in    = digit_char(rd_digit);
               last_in    = is_last;
               started_in = 1'b1;
            end
            cnt_in = cnt_m1;
            if (is_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
      cnt_ff     <= cnt_in;
      neg_ff     <= neg_in;
      started_ff <= started_in;
      char_ff    <= char_in;
      last_ff    <= last_in;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_char_code = char_ff;
   assign rsp_last_char = last_ff;

endmodule

// ===== design/itra_checker.sv =====
// Port-level checks for the integer to radix ASCII converter, bound to the top level.
module itra_checker #(
   parameter int VALUE_WIDTH = 32
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic signed [VALUE_WIDTH-1:0] req_value,
   input logic [1:0]                    req_base_select,
   input logic                          rsp_strobe,
   input itra_pkg::char_type            rsp_char_code,
   input logic                          rsp_last_char
);
   import itra_pkg::*;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("transfer accepted but block not busy");

   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_char |-> busy)
      else $error("non-final character shown while idle");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe && rsp_last_char)
      else $error("block went idle without final character");

   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last_char |=> !rsp_strobe)
      else $error("character right after final character");

   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_char_code == CHAR_MINUS) |-> !rsp_last_char)
      else $error("sign flagged as final character");

endmodule

bind integer_to_radix_ascii_top itra_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_itra_checker (.*);

// ===== tb/tb_integer_to_radix_ascii_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the signed integer to radix ASCII converter.
module tb_integer_to_radix_ascii_top;
   import itra_pkg::*;

   localparam int VALUE_WIDTH  = 32;
   localparam int IDLE_PERCENT = 36;
   localparam int RANDOM_ITEMS = 470;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = VALUE_WIDTH + 16;

   typedef logic [VALUE_WIDTH-1:0] word_type;

   typedef struct {
      char_type code;
      logic     last;
   } text_char_type;

   class text_scoreboard;
      text_char_type expected_text[$];
      int            errors;

      function new();
         errors = 0;
      endfunction

      task report(string msg);
         $display("%0t ns: %s", $time, msg);
         errors++;
      endtask

      // Spells the number in the selected radix, sign first, and queues the characters.
      function void note_number(word_type value, base_type base);
         word_type      magnitude;
         word_type      radix;
         word_type      digit;
         char_type      digits[$];
         text_char_type entry;
         case (base)
            BASE_DEC: radix = 10;
            BASE_HEX: radix = 16;
            BASE_OCT: radix = 8;
            default:  radix = 2;
         endcase
         magnitude = value[VALUE_WIDTH-1] ? -value : value;
         do begin
            digit = magnitude % radix;
            if (digit >= 10) begin
               digits.push_front(char_type'(digit) + ALPHA_OFFSET);
            end else begin
               digits.push_front(char_type'(digit) + CHAR_ZERO);
            end
            magnitude = magnitude / radix;
         end while (magnitude != 0);
         if (value[VALUE_WIDTH-1]) begin
            entry.code = CHAR_MINUS;
            entry.last = 1'b0;
            expected_text.push_back(entry);
         end
         foreach (digits[i]) begin
            entry.code = digits[i];
            entry.last = (i == digits.size() - 1);
            expected_text.push_back(entry);
         end
      endfunction

      task check_char(char_type code, logic last);
         text_char_type want;
         if (expected_text.size() == 0) begin
            report($sformatf("unexpected char 0x%02h last %b", code, last));
         end else begin
            want = expected_text.pop_front();
            if (code !== want.code) begin
               report($sformatf("char 0x%02h, expected 0x%02h", code, want.code));
            end
            if (last !== want.last) begin
               report($sformatf("last flag %b on char 0x%02h, expected %b",
                                last, want.code, want.last));
            end
         end
      endtask
   endclass

   logic               clock           = 1'b0;
   logic               reset           = 1'b1;
   logic               start           = 1'b0;
   logic               busy;
   word_type           req_value       = '0;
   logic [1:0]         req_base_select = BASE_DEC;
   logic               rsp_strobe;
   char_type           rsp_char_code;
   logic               rsp_last_char;
   int                 stall_cycles    = 0;
   text_scoreboard     board           = new();

   integer_to_radix_ascii_top #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_value      (req_value),
      .req_base_select(req_base_select),
      .rsp_strobe     (rsp_strobe),
      .rsp_char_code  (rsp_char_code),
      .rsp_last_char  (rsp_last_char)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         board.check_char(rsp_char_code, rsp_last_char);
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_strobe === 1'b1 || (start && busy === 1'b0)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic idle_sender(bit no_idle);
      if (!no_idle) begin
         while ($urandom_range(99) < IDLE_PERCENT) begin
            start <= 1'b0;
            @(posedge clock);
         end
         // occasional longer hold-off so the idle gap between conversions varies
         if ($urandom_range(7) == 0) begin
            repeat ($urandom_range(1, 40)) begin
               start <= 1'b0;
               @(posedge clock);
            end
         end
      end
   endtask

   task automatic send_number(word_type value, base_type base, bit no_idle);
      idle_sender(no_idle);
      start           <= 1'b1;
      req_value       <= value;
      req_base_select <= base;
      do begin
         @(posedge clock);
      end while (busy !== 1'b0);
      board.note_number(value, base);
   endtask

   function automatic word_type random_value();
      word_type v;
      v = $urandom;
      case ($urandom_range(5))
         0: v = v >> $urandom_range(VALUE_WIDTH - 1);
         1: v = -(v >> $urandom_range(VALUE_WIDTH - 1));
         2: v = $urandom_range(40) - 20;
         3: v = {1'b1, {(VALUE_WIDTH-1){1'b0}}} + $urandom_range(3);
         4: v = {1'b0, {(VALUE_WIDTH-1){1'b1}}} - $urandom_range(3);
         default: ;
      endcase
      return v;
   endfunction

   initial begin
      word_type extremes[4];
      extremes[0] = '0;
      extremes[1] = '1;
      extremes[2] = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
      extremes[3] = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (extremes[e]) begin
         for (int b = 0; b < 4; b++) begin
            send_number(extremes[e], base_type'(b), 1'b0);
         end
      end
      send_number(10, BASE_HEX, 1'b0);
      send_number(15, BASE_HEX, 1'b0);
      send_number(32'h00AB_CDEF, BASE_HEX, 1'b0);
      send_number(-10, BASE_HEX, 1'b0);
      send_number(9, BASE_DEC, 1'b0);
      send_number(-1234567890, BASE_DEC, 1'b0);
      send_number(7, BASE_OCT, 1'b0);
      send_number(1, BASE_BIN, 1'b0);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         send_number(random_value(), base_type'($urandom_range(3)), i >= 150 && i < 260);
      end
      start <= 1'b0;

      while (board.expected_text.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/itra_pkg.sv
design/itra_conv.sv
design/integer_to_radix_ascii_top.sv
design/itra_checker.sv
tb/tb_integer_to_radix_ascii_top.sv
